@@ rtl/ffra_pkg.sv @@
package ffra_pkg;

  localparam int unsigned NUM_BLOCKS  = 64;
  localparam int unsigned ALIGN_LOG2  = 6;
  localparam int unsigned ALIGN_BYTES = 1 << ALIGN_LOG2;
  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned LEN_W       = 25;
  localparam int unsigned SIZE_W      = LEN_W + 1;
  localparam int unsigned CNT_W       = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned SLOT_N      = NUM_BLOCKS + 1;
  localparam int unsigned CAP_BITS    = (OFFSET_BITS < LEN_W) ? OFFSET_BITS : LEN_W;
  localparam logic [SIZE_W-1:0] LIMIT_CAP = SIZE_W'(1) << CAP_BITS;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_REGION_SIZE = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_e;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [LEN_W-1:0]       length;
  } cell_data_t;

  typedef struct packed {
    cell_op_e   op;
    cell_data_t load;
  } cell_ctrl_t;

endpackage

@@ rtl/ffra_if.sv @@
interface ffra_req_if import ffra_pkg::*;;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [LEN_W-1:0]  request_size;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, operation, request_size, block_address, input ready);
  modport sink   (input valid, operation, request_size, block_address, output ready);
endinterface

interface ffra_rsp_if import ffra_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] granted_address;
  logic [LEN_W-1:0]  granted_size;
  logic [LEN_W-1:0]  bytes_available;

  modport source (output valid, status, granted_address, granted_size, bytes_available,
                  input ready);
  modport sink   (input valid, status, granted_address, granted_size, bytes_available,
                  output ready);
endinterface

@@ rtl/ffra_cell.sv @@
// One table entry: holds a block, tests its gap, shifts to/from neighbours.
module ffra_cell import ffra_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  cell_data_t        prev_i,
  input  cell_data_t        next_i,
  input  logic [SIZE_W-1:0] prev_end_i,
  input  logic              valid_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic [ADDR_W-1:0] free_off_i,
  output cell_data_t        data_o,
  output logic [SIZE_W-1:0] end_o,
  output logic              fit_o,
  output logic              match_o
);

  cell_data_t        data_q, data_d;
  logic [SIZE_W:0]   need;

  always_comb begin
    case (ctrl_i.op)
      CELL_LOAD:      data_d = ctrl_i.load;
      CELL_FROM_PREV: data_d = prev_i;
      CELL_FROM_NEXT: data_d = next_i;
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign need    = {1'b0, prev_end_i} + {1'b0, size_i};
  assign end_o   = SIZE_W'(data_q.offset) + SIZE_W'(data_q.length);
  // an empty cell marks the tail gap
  assign fit_o   = !valid_i || (need <= (SIZE_W + 1)'(data_q.offset));
  assign match_o = valid_i && (free_off_i == ADDR_W'(data_q.offset));
  assign data_o  = data_q;

endmodule

@@ rtl/first_fit_region_allocator.sv @@
// First-fit allocator for one memory region. Blocks live in a row of 64 cells kept sorted by
// start offset; an allocate word rounds its size up to a multiple of 64 bytes and takes the
// lowest gap that fits (the tail after the last block included), a free word removes the block
// with that exact start address. The response word of an item comes after these steps: the
// acceptance edge latches it, then all cells test their gap or address at once, the first hit
// is picked, that slot's position is fetched, and the row is shifted and the response written.
// One item is in flight at a time; the next is taken the cycle after the row has been updated,
// and a response left waiting on the output holds the update step until it is taken. The user
// must write region_base and region_size through the cfg port only while idle; the block
// itself does not enforce it. Offsets are relative, so moving the base moves all blocks.
module first_fit_region_allocator import ffra_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  ffra_req_if.sink          req_i,
  ffra_rsp_if.source        rsp_o
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_PICK, S_MUX, S_COMMIT} state_e;

  state_e state_q;

  logic [ADDR_W-1:0] base_q;
  logic [LEN_W-1:0]  rsize_q;
  logic [CNT_W-1:0]  count_q;
  logic [LEN_W-1:0]  in_use_q, in_use_d;

  // latched request
  logic              op_q;
  logic              early_fail_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] off_q;

  logic [SLOT_N-1:0] hit_q, sel_q, below_q, hit_m1;
  logic [SIZE_W-1:0] pos_q;
  logic [LEN_W-1:0]  len_q;
  logic              found_q;

  // response word
  logic              rsp_valid_q;
  logic [1:0]        status_q;
  logic [ADDR_W-1:0] gaddr_q;
  logic [LEN_W-1:0]  gsize_q;
  logic [LEN_W-1:0]  avail_q;

  // cell row
  cell_data_t        cdata [NUM_BLOCKS];
  cell_ctrl_t        cctrl [NUM_BLOCKS];
  logic [SIZE_W-1:0] cend  [NUM_BLOCKS];
  logic [SIZE_W-1:0] pend  [SLOT_N];
  logic [NUM_BLOCKS-1:0] fit, match;

  logic [SIZE_W-1:0] limit, req_round;
  logic [SIZE_W:0]   pos_end;
  logic              commit, alloc_ok, free_ok;
  logic [1:0]        status_d;
  logic [SIZE_W-1:0] pos_mux;
  logic [LEN_W-1:0]  len_mux;

  assign limit     = ({1'b0, rsize_q} < LIMIT_CAP) ? {1'b0, rsize_q} : LIMIT_CAP;
  assign req_round = (({1'b0, req_i.request_size} + SIZE_W'(ALIGN_BYTES - 1)) >> ALIGN_LOG2)
                     << ALIGN_LOG2;

  assign pend[0] = '0;
  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    cell_data_t prv, nxt;
    assign prv = (i == 0) ? '0 : cdata[(i == 0) ? 0 : i - 1];
    assign nxt = (i == NUM_BLOCKS - 1) ? '0 : cdata[(i == NUM_BLOCKS - 1) ? i : i + 1];
    assign pend[i + 1] = cend[i];

    ffra_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cctrl[i]),
      .prev_i     (prv),
      .next_i     (nxt),
      .prev_end_i (pend[i]),
      .valid_i    (CNT_W'(i) < count_q),
      .size_i     (size_q),
      .free_off_i (off_q),
      .data_o     (cdata[i]),
      .end_o      (cend[i]),
      .fit_o      (fit[i]),
      .match_o    (match[i])
    );

    always_comb begin
      cctrl[i].load.offset = OFFSET_BITS'(pos_q);
      cctrl[i].load.length = LEN_W'(size_q);
      cctrl[i].op          = CELL_HOLD;
      if (below_q[i]) begin
        cctrl[i].op = CELL_HOLD;
      end else if (alloc_ok) begin
        cctrl[i].op = sel_q[i] ? CELL_LOAD : CELL_FROM_PREV;
      end else if (free_ok) begin
        cctrl[i].op = CELL_FROM_NEXT;
      end
    end
  end

  // one-hot fetch of the chosen slot's gap start and length
  always_comb begin
    pos_mux = '0;
    len_mux = '0;
    for (int unsigned k = 0; k < SLOT_N; k++) begin
      pos_mux = pos_mux | (pend[k] & {SIZE_W{sel_q[k]}});
    end
    for (int unsigned k = 0; k < NUM_BLOCKS; k++) begin
      len_mux = len_mux | (cdata[k].length & {LEN_W{sel_q[k]}});
    end
  end

  assign hit_m1  = hit_q - SLOT_N'(1);
  assign pos_end = {1'b0, pos_q} + {1'b0, size_q};
  assign commit  = (state_q == S_COMMIT) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    alloc_ok = 1'b0;
    free_ok  = 1'b0;
    in_use_d = in_use_q;
    if (op_q == OP_ALLOC) begin
      if (early_fail_q || pos_end > {1'b0, limit}) begin
        status_d = ST_NOSPACE;
      end else if (count_q == CNT_W'(NUM_BLOCKS)) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_OK;
        alloc_ok = commit;
        in_use_d = in_use_q + LEN_W'(size_q);
      end
    end else begin
      if (!found_q) begin
        status_d = ST_MISSING;
      end else begin
        status_d = ST_OK;
        free_ok  = commit;
        in_use_d = (in_use_q >= len_q) ? in_use_q - len_q : '0;
      end
    end
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= ADDR_W'(32'h0400_0000);
      rsize_q     <= LEN_W'(25'h020_0000);
      count_q     <= '0;
      in_use_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REGION_BASE: base_q  <= cfg_data_i;
          CFG_REGION_SIZE: rsize_q <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      // a new word replaces one taken in the same cycle
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) state_q <= S_EVAL;
        end
        S_EVAL:  state_q <= S_PICK;
        S_PICK:  state_q <= S_MUX;
        S_MUX:   state_q <= S_COMMIT;
        S_COMMIT: begin
          if (commit) begin
            state_q     <= S_IDLE;
            in_use_q    <= in_use_d;
            if (alloc_ok) count_q <= count_q + CNT_W'(1);
            if (free_ok)  count_q <= count_q - CNT_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q         <= req_i.operation;
      size_q       <= req_round;
      early_fail_q <= (req_i.request_size == '0) || (req_round > limit);
      addr_q       <= req_i.block_address;
      off_q        <= req_i.block_address - base_q;
    end
    if (state_q == S_EVAL) begin
      hit_q <= (op_q == OP_FREE) ? {1'b0, match} : {1'b1, fit};
    end
    if (state_q == S_PICK) begin
      sel_q   <= hit_q & ~hit_m1;
      below_q <= hit_m1 & ~hit_q;
    end
    if (state_q == S_MUX) begin
      pos_q   <= pos_mux;
      len_q   <= len_mux;
      found_q <= |sel_q;
    end
    if (commit) begin
      status_q <= status_d;
      avail_q  <= (rsize_q > in_use_d) ? rsize_q - in_use_d : '0;
      if (status_d != ST_OK) begin
        gaddr_q <= '0;
        gsize_q <= '0;
      end else if (op_q == OP_ALLOC) begin
        gaddr_q <= base_q + ADDR_W'(pos_q);
        gsize_q <= LEN_W'(size_q);
      end else begin
        gaddr_q <= addr_q;
        gsize_q <= len_q;
      end
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.granted_address = gaddr_q;
  assign rsp_o.granted_size    = gsize_q;
  assign rsp_o.bytes_available = avail_q;

endmodule

@@ tb/sv/first_fit_region_allocator_test.sv @@
module first_fit_region_allocator_test;
  import ffra_pkg::*;

  localparam int unsigned RAND_WORDS = 1150;
  localparam int unsigned CYCLE_CAP  = 2000000;
  localparam int unsigned DRAIN_WAIT = 16;  // idle margin after the last response, over the allocator pipe

  typedef struct {
    logic              operation;
    logic [LEN_W-1:0]  request_size;
    logic [ADDR_W-1:0] block_address;
  } alloc_req_t;

  typedef struct {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic [LEN_W-1:0]  granted_size;
    logic [LEN_W-1:0]  bytes_available;
  } alloc_rsp_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [ADDR_W-1:0] cfg_data_i;

  ffra_req_if req_if ();
  ffra_rsp_if rsp_if ();

  first_fit_region_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  // Shadow of the block table: sorted offsets, lengths, occupancy.
  logic [ADDR_W-1:0]      shadow_base;
  logic [LEN_W-1:0]       shadow_size;
  logic [OFFSET_BITS-1:0] shadow_offset [NUM_BLOCKS];
  logic [LEN_W-1:0]       shadow_length [NUM_BLOCKS];
  int unsigned            shadow_count;
  logic [LEN_W-1:0]       shadow_in_use;

  alloc_req_t  pending_words [$];
  alloc_rsp_t  responses_due [$];
  alloc_req_t  cur_word;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned words_sent;
  int unsigned status_seen [4];
  int unsigned full_table_hits;

  // Clock: period 2.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // First-fit prediction for one accepted word; updates the shadow table.
  function automatic alloc_rsp_t predict_allocation(alloc_req_t w);
    alloc_rsp_t        r;
    longint unsigned   rounded, limit, pos, off;
    int unsigned       slot;
    bit                hit;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] off32;
    r = '{status: ST_OK, granted_address: '0, granted_size: '0, bytes_available: '0};
    if (w.operation == OP_ALLOC) begin
      rounded = ((longint'(w.request_size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
      limit = (longint'(shadow_size) < (64'd1 << OFFSET_BITS)) ? longint'(shadow_size)
                                                                : (64'd1 << OFFSET_BITS);
      pos  = 0;
      slot = shadow_count;
      if (w.request_size == '0 || rounded > limit) begin
        r.status = ST_NOSPACE;
      end else begin
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (pos + rounded <= longint'(shadow_offset[i])) begin
            slot = i;
            break;
          end
          pos = longint'(shadow_offset[i]) + longint'(shadow_length[i]);
        end
        if (pos + rounded > limit) begin
          r.status = ST_NOSPACE;
        end else if (shadow_count >= NUM_BLOCKS) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned i = shadow_count; i > slot; i--) begin
            shadow_offset[i] = shadow_offset[i-1];
            shadow_length[i] = shadow_length[i-1];
          end
          shadow_offset[slot] = pos[OFFSET_BITS-1:0];
          shadow_length[slot] = rounded[LEN_W-1:0];
          shadow_count++;
          shadow_in_use = shadow_in_use + rounded[LEN_W-1:0];
          r.granted_address = shadow_base + pos[ADDR_W-1:0];
          r.granted_size    = rounded[LEN_W-1:0];
        end
      end
    end else begin
      off32 = w.block_address - shadow_base;  // 32-bit wrap
      off   = longint'(off32);
      hit = 1'b0;
      for (int unsigned i = 0; i < shadow_count; i++) begin
        if (!hit && longint'(shadow_offset[i]) == off) begin
          hit = 1'b1;
          len = shadow_length[i];
          for (int unsigned j = i; j + 1 < shadow_count; j++) begin
            shadow_offset[j] = shadow_offset[j+1];
            shadow_length[j] = shadow_length[j+1];
          end
          shadow_count--;
          shadow_in_use = (shadow_in_use >= len) ? shadow_in_use - len : '0;
          r.granted_address = w.block_address;
          r.granted_size    = len;
        end
      end
      if (!hit) r.status = ST_MISSING;
    end
    r.bytes_available = (shadow_size > shadow_in_use) ? shadow_size - shadow_in_use : '0;
    return r;
  endfunction

  // Driver: a word moves on valid & ready; next word or an idle gap follows.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        responses_due.push_back(predict_allocation(cur_word));
        words_sent++;
      end
      if (pending_words.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        cur_word = pending_words.pop_front();
        req_if.valid         <= 1'b1;
        req_if.operation     <= cur_word.operation;
        req_if.request_size  <= cur_word.request_size;
        req_if.block_address <= cur_word.block_address;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, field-by-field compare against oldest due word.
  always @(posedge clk_i) begin
    alloc_rsp_t due;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (responses_due.size() == 0) begin
          $error("response word with nothing outstanding");
          error_count++;
        end else begin
          due = responses_due.pop_front();
          status_seen[due.status]++;
          if (due.status == ST_FULL) full_table_hits++;
          if (rsp_if.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, rsp_if.status);
            error_count++;
          end
          if (rsp_if.granted_address !== due.granted_address) begin
            $error("granted_address: expected %h, got %h",
                   due.granted_address, rsp_if.granted_address);
            error_count++;
          end
          if (rsp_if.granted_size !== due.granted_size) begin
            $error("granted_size: expected %h, got %h", due.granted_size, rsp_if.granted_size);
            error_count++;
          end
          if (rsp_if.bytes_available !== due.bytes_available) begin
            $error("bytes_available: expected %h, got %h",
                   due.bytes_available, rsp_if.bytes_available);
            error_count++;
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               responses_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_word(logic op, logic [LEN_W-1:0] sz, logic [ADDR_W-1:0] addr);
    pending_words.push_back('{operation: op, request_size: sz, block_address: addr});
  endtask

  // Waits until the pipe is empty and the last word has fully retired.
  task automatic drain_pipe();
    do @(posedge clk_i);
    while (pending_words.size() > 0 || req_if.valid || responses_due.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_region(logic idx, logic [ADDR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == CFG_REGION_BASE) shadow_base = value;
    else                        shadow_size = value[LEN_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic: mostly allocs of modest size and frees of live blocks; some
  // full-range sizes, zero sizes and stray addresses.
  task automatic random_traffic(int unsigned n, int unsigned alloc_pct);
    int unsigned      pick, k;
    logic [LEN_W-1:0] sz;
    for (int unsigned i = 0; i < n; i++) begin
      while (pending_words.size() >= 3) @(posedge clk_i);
      pick = $urandom_range(99);
      if (pick < alloc_pct) begin
        k = $urandom_range(19);
        if (k == 0)      sz = '0;
        else if (k < 3)  sz = LEN_W'($urandom_range((1 << LEN_W) - 1));
        else if (k < 8)  sz = LEN_W'($urandom_range(1, ALIGN_BYTES));
        else             sz = LEN_W'($urandom_range(1, 8192));
        queue_word(OP_ALLOC, sz, $urandom);
      end else if (pick < 92 && shadow_count > 0) begin
        k = $urandom_range(shadow_count - 1);
        queue_word(OP_FREE, LEN_W'($urandom), shadow_base + ADDR_W'(shadow_offset[k]));
      end else begin
        queue_word(OP_FREE, LEN_W'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_REGION_BASE;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.operation     = OP_ALLOC;
    req_if.request_size  = '0;
    req_if.block_address = '0;
    rsp_if.ready = 1'b0;
    send_gap_pct = 0;
    stall_pct    = 0;
    error_count  = 0;
    cycle_count  = 0;
    words_sent   = 0;
    full_table_hits = 0;
    status_seen  = '{default: 0};
    shadow_base   = 32'h0400_0000;
    shadow_size   = 25'h20_0000;
    shadow_count  = 0;
    shadow_in_use = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero size, alignment edges, oversize, tail overflow, gap reuse, misses.
    queue_word(OP_ALLOC, '0, '0);
    queue_word(OP_ALLOC, 25'd1, '0);
    queue_word(OP_ALLOC, 25'd64, '1);
    queue_word(OP_ALLOC, 25'd65, '0);
    queue_word(OP_ALLOC, '1, '0);               // way past the region
    queue_word(OP_ALLOC, 25'h100_0000, '0);     // usable cap, bigger than region
    queue_word(OP_FREE, '0, 32'h0400_0000);     // first block, leaves a hole at the bottom
    queue_word(OP_ALLOC, 25'd64, '0);           // first fit reuses the hole
    queue_word(OP_FREE, '1, 32'h0400_0040);
    queue_word(OP_FREE, '0, 32'h0400_0040);     // already gone
    queue_word(OP_FREE, '0, '0);
    queue_word(OP_FREE, '0, '1);
    queue_word(OP_ALLOC, 25'h20_0000 - 25'd192, '0);  // 64 bytes more than the tail holds: no space
    queue_word(OP_ALLOC, 25'd1, '0);                  // first fit takes the hole at offset 0x40
    queue_word(OP_FREE, '0, 32'h0400_00c0);
    drain_pipe();

    // Region wraps past the top of the address space, full 16 MiB; fill the table.
    write_region(CFG_REGION_BASE, 32'hFFFF_FFC0);
    write_region(CFG_REGION_SIZE, 32'h100_0000);
    send_gap_pct = 25; stall_pct = 68;
    random_traffic(300, 85);
    drain_pipe();  // sender holds off until every response has come back

    send_gap_pct = 68; stall_pct = 25;
    random_traffic(250, 60);
    drain_pipe();

    // Shrink below what is in use: bytes_available saturates, blocks stay.
    write_region(CFG_REGION_SIZE, 32'h0000_1000);
    write_region(CFG_REGION_BASE, 32'h0000_0000);
    random_traffic(150, 50);
    drain_pipe();

    // Empty region, then one larger than the usable cap.
    write_region(CFG_REGION_SIZE, 32'h0);
    send_gap_pct = 0; stall_pct = 0;
    random_traffic(100, 50);
    drain_pipe();
    write_region(CFG_REGION_SIZE, 32'h1FF_FFFF);
    write_region(CFG_REGION_BASE, 32'hFFFF_FFFF);
    random_traffic(350, 65);
    drain_pipe();

    $display("%0d words, status ok/no-space/full/missing = %0d/%0d/%0d/%0d",
             words_sent, status_seen[ST_OK], status_seen[ST_NOSPACE],
             status_seen[ST_FULL], status_seen[ST_MISSING]);
    $display("register settings: reset, wrapping base, 16 MiB, shrunk, zero, oversize");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ffra_pkg.sv
rtl/ffra_if.sv
rtl/ffra_cell.sv
rtl/first_fit_region_allocator.sv
tb/sv/first_fit_region_allocator_test.sv
